### hw/rtl/stt_pkg.sv
// Shared constants and types for the symbol table insert/update block.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   // Default sizing, used as the defaults of the top level parameters
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_BYTES_DEF   = 8;

   // Fixed field widths of the request and response channels
   localparam int ENTITY_KEY_W  = 64;
   localparam int ENTITY_CODE_W = 64;
   localparam int SLOT_INDEX_W  = 6;
   localparam int STATUS_W      = 2;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_NEW     = 2'd0,
      STATUS_UPDATED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // Control part of the search token that walks the cell row
   typedef struct packed {
      logic active;   // token present at this cell boundary
      logic sel;      // table select: 0 keyword, 1 separator
      logic hit;      // an earlier cell already took the transfer
      logic updated;  // the taking cell held a matching key
   } tok_ctl_type;

endpackage : stt_pkg

`default_nettype wire

### hw/rtl/stt_cell.sv
// One cell of the symbol table row: holds entry CELL_INDEX of both tables.
`timescale 1ns / 1ps
`default_nettype none

module stt_cell
   import stt_pkg::*;
#(
   parameter int KEY_W      = 64,
   parameter int SLOT_W     = 6,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tok_ctl_type              ctl_i,
   input  wire logic [KEY_W-1:0]         key_i,
   input  wire logic [ENTITY_CODE_W-1:0] code_i,
   input  wire logic [SLOT_W-1:0]        slot_i,
   output tok_ctl_type                   ctl_o,
   output logic [KEY_W-1:0]              key_o,
   output logic [ENTITY_CODE_W-1:0]      code_o,
   output logic [SLOT_W-1:0]             slot_o
);

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);

   // Entry storage, index 0 keyword table, index 1 separator table
   logic [1:0]               valid_ff;
   logic [KEY_W-1:0]         key_ff  [2];
   logic [ENTITY_CODE_W-1:0] code_ff [2];

   tok_ctl_type              ctl_ff, ctl_in;
   logic [KEY_W-1:0]         tok_key_ff;
   logic [ENTITY_CODE_W-1:0] tok_code_ff;
   logic [SLOT_W-1:0]        tok_slot_ff, tok_slot_in;
   logic                     take;

   // Take the transfer at the first free entry or the first matching key
   always_comb begin
      take        = ctl_i.active && !ctl_i.hit &&
                    (!valid_ff[ctl_i.sel] || (key_ff[ctl_i.sel] == key_i));
      ctl_in      = ctl_i;
      tok_slot_in = slot_i;
      if (take) begin
         ctl_in.hit     = 1'b1;
         ctl_in.updated = valid_ff[ctl_i.sel];
         tok_slot_in    = MY_SLOT;
      end
   end

   // Write the entry and mark it valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (take) begin
         valid_ff[ctl_i.sel] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_ff[ctl_i.sel]  <= key_i;
         code_ff[ctl_i.sel] <= code_i;
      end
   end

   // Advance the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_key_ff  <= key_i;
      tok_code_ff <= code_i;
      tok_slot_ff <= tok_slot_in;
   end

   assign ctl_o  = ctl_ff;
   assign key_o  = tok_key_ff;
   assign code_o = tok_code_ff;
   assign slot_o = tok_slot_ff;

endmodule : stt_cell

`default_nettype wire

### hw/rtl/symbol_table_insert_or_update_top.sv
// Top level of the symbol table insert/update block: cell row and handshakes.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a keyword table and a separator table of TABLE_DEPTH entries each,
// held in a row of TABLE_DEPTH cells (cell i holds entry i of both tables).
// A request transfer starts a search token at cell 0; the token moves one
// cell per clock, and the first cell whose entry is free or holds the same
// key (low KEY_BYTES bytes) stores key and code and marks the token taken.
// The response carries the slot taken and the status new, updated or full.
// One request is in work at a time: a response is ready once its token has
// left the last cell and its result has passed the result register, and the
// next request is taken once that result has moved to the output register,
// which waits while a stalled response still holds that register. A finished
// response may wait in the output register while the next request is in work.
module symbol_table_insert_or_update_top
   import stt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_opcode,
   input  wire logic [ENTITY_KEY_W-1:0]  req_entity_key,
   input  wire logic [ENTITY_CODE_W-1:0] req_entity_code,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [SLOT_INDEX_W-1:0]       rsp_slot_index,
   output logic [STATUS_W-1:0]           rsp_status
);

   localparam int KEY_W  = 8 * KEY_BYTES;
   localparam int SLOT_W = $clog2(TABLE_DEPTH);

   // Token signals at each cell boundary; index 0 is the row input
   tok_ctl_type              ctl_w  [TABLE_DEPTH+1];
   logic [KEY_W-1:0]         key_w  [TABLE_DEPTH+1];
   logic [ENTITY_CODE_W-1:0] code_w [TABLE_DEPTH+1];
   logic [SLOT_W-1:0]        slot_w [TABLE_DEPTH+1];

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [SLOT_INDEX_W-1:0]  res_slot_ff, res_slot_in;
   status_type               res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SLOT_INDEX_W-1:0]  rsp_slot_ff;
   status_type               rsp_status_ff;
   logic                     req_xfer;
   logic                     load_rsp;
   logic [SLOT_W+SLOT_INDEX_W-1:0] tail_slot_ext;

   // Hold off requests while one is in work or the block is in reset
   assign req_stall = busy_ff || reset;
   assign req_xfer  = req_valid && !req_stall;

   // Build the token that enters cell 0
   always_comb begin
      ctl_w[0]         = '0;
      ctl_w[0].active  = req_xfer;
      ctl_w[0].sel     = req_opcode;
      key_w[0]         = req_entity_key[KEY_W-1:0];
      code_w[0]        = req_entity_code;
      slot_w[0]        = '0;
   end

   // Row of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      stt_cell #(
         .KEY_W      (KEY_W),
         .SLOT_W     (SLOT_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (ctl_w[i]),
         .key_i  (key_w[i]),
         .code_i (code_w[i]),
         .slot_i (slot_w[i]),
         .ctl_o  (ctl_w[i+1]),
         .key_o  (key_w[i+1]),
         .code_o (code_w[i+1]),
         .slot_o (slot_w[i+1])
      );
   end

   // Turn the token leaving the last cell into a result
   assign tail_slot_ext = {{SLOT_INDEX_W{1'b0}}, slot_w[TABLE_DEPTH]};

   always_comb begin
      load_rsp = done_ff && (!rsp_valid_ff || !rsp_stall);

      done_in       = done_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      if (ctl_w[TABLE_DEPTH].active) begin
         done_in = 1'b1;
         if (ctl_w[TABLE_DEPTH].hit) begin
            res_slot_in   = tail_slot_ext[SLOT_INDEX_W-1:0];
            res_status_in = ctl_w[TABLE_DEPTH].updated ? STATUS_UPDATED : STATUS_NEW;
         end else begin
            res_slot_in   = '0;
            res_status_in = STATUS_FULL;
         end
      end else if (load_rsp) begin
         done_in = 1'b0;
      end

      // Hold off requests until the result has moved to the output register
      busy_in = busy_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
      end else if (load_rsp) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      if (load_rsp) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

endmodule : symbol_table_insert_or_update_top

`default_nettype wire
